### hw/rtl/qgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants and types of the qam gray hard demapper
package qgd_pkg;

   localparam int SAMPLE_FRAC = 11;
   localparam int SCALE_FRAC  = 12;
   localparam int FRAC_BITS   = SAMPLE_FRAC + SCALE_FRAC;
   localparam int SCALE_WIDTH = 16;
   localparam int BPS_WIDTH   = 4;
   localparam int HALF_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BITS_PER_SYMBOL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REV_SCALE       = 2'd1;

   localparam logic [BPS_WIDTH-1:0]   BPS_RESET       = 4'd2;
   localparam logic [SCALE_WIDTH-1:0] REV_SCALE_RESET = 16'd4096;

   typedef struct packed {
      logic                  bpsk;
      logic [HALF_WIDTH-1:0] half;
   } sym_ctrl_type;

endpackage
`default_nettype wire

### hw/rtl/qgd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// sample channel: valid, ready and the complex sample
interface qgd_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_i;
   logic signed [SAMPLE_WIDTH-1:0] sample_q;

   modport source (output valid, output sample_i, output sample_q, input ready);
   modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface
`default_nettype wire

### hw/rtl/qgd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// decision channel: valid, ready and the packed symbol bits
interface qgd_rsp_if #(
   parameter int MAX_BITS_PER_SYMBOL = 8
);
   logic                           valid;
   logic                           ready;
   logic [MAX_BITS_PER_SYMBOL-1:0] symbol_bits;

   modport source (output valid, output symbol_bits, input ready);
   modport sink (input valid, input symbol_bits, output ready);
endinterface
`default_nettype wire

### hw/rtl/qgd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// one axis lane: scale multiply register, level decision and gray coding
module qgd_lane
   import qgd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int LEVEL_WIDTH  = 4
) (
   input  wire                           clock,
   input  wire                           load_en,
   input  wire signed [SAMPLE_WIDTH-1:0] sample,
   input  wire [SCALE_WIDTH-1:0]         rev_scale,
   input  wire [HALF_WIDTH-1:0]          half,
   output logic [LEVEL_WIDTH-1:0]        gray_level
);

   localparam int PW = SAMPLE_WIDTH + SCALE_WIDTH + 1;
   localparam int MW = LEVEL_WIDTH + FRAC_BITS + 2;
   localparam int NW = ((PW > MW) ? PW : MW) + 1;
   localparam int HW = NW - (FRAC_BITS + 1);

   logic signed [PW-1:0] product_ff;
   logic signed [PW-1:0] product_in;
   logic [HW-1:0]        m_val;
   logic [HW-1:0]        mask;
   logic [NW-1:0]        m_term;
   logic [NW-1:0]        n_sum;
   logic [HW-1:0]        lvl_raw;
   logic [LEVEL_WIDTH-1:0] level;

   assign product_in = sample * $signed({1'b0, rev_scale});

   always_ff @(posedge clock) begin
      if (load_en) begin
         product_ff <= product_in;
      end
   end

   // (v + m) / 2 in units of the product scale, floored
   assign m_val   = HW'(1) << half;
   assign mask    = m_val - HW'(1);
   assign m_term  = {1'b0, m_val, {FRAC_BITS{1'b0}}};
   assign n_sum   = {{(NW-PW){product_ff[PW-1]}}, product_ff} + m_term;
   assign lvl_raw = n_sum[NW-1:FRAC_BITS+1];

   always_comb begin
      if (n_sum[NW-1]) begin
         level = '0;
      end else if (lvl_raw > mask) begin
         level = mask[LEVEL_WIDTH-1:0];
      end else begin
         level = lvl_raw[LEVEL_WIDTH-1:0];
      end
   end

   assign gray_level = level ^ (level >> 1);

endmodule
`default_nettype wire

### hw/rtl/qgd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// merge stage: packs the lane decisions into the output register
module qgd_merge
   import qgd_pkg::*;
#(
   parameter int MAX_BITS_PER_SYMBOL = 8,
   parameter int LEVEL_WIDTH         = 4
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire sym_ctrl_type           ctrl,
   input  wire [LEVEL_WIDTH-1:0]       level_i,
   input  wire [LEVEL_WIDTH-1:0]       level_q,
   qgd_rsp_if.source                   rsp
);

   logic                           valid_ff;
   logic [MAX_BITS_PER_SYMBOL-1:0] bits_ff;
   logic [MAX_BITS_PER_SYMBOL-1:0] bits_in;

   assign in_ready = !valid_ff || rsp.ready;

   always_comb begin
      if (ctrl.bpsk) begin
         bits_in = MAX_BITS_PER_SYMBOL'(level_i);
      end else begin
         bits_in = (MAX_BITS_PER_SYMBOL'(level_i) << ctrl.half)
                 | MAX_BITS_PER_SYMBOL'(level_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         bits_ff <= bits_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.symbol_bits = bits_ff;

endmodule
`default_nettype wire

### hw/rtl/qam_gray_hard_demapper.sv
`timescale 1ns / 1ps
`default_nettype none
// qam gray hard demapper top level: csr block, two axis lanes and merge stage
// path: a sample is registered in the multiply stage, then in the merge output register
// throughput: 1 sample per cycle without rsp stalls, via multiply stage and output register
// each stage holds its item only while the stage after it is stalled
// reset: synchronous, clears both stage valids and loads bits_per_symbol 2, rev_scale 4096
module qam_gray_hard_demapper
   import qgd_pkg::*;
#(
   parameter int MAX_BITS_PER_SYMBOL = 8,
   parameter int SAMPLE_WIDTH        = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]   csr_wdata,
   qgd_req_if.sink                    req_bus,
   qgd_rsp_if.source                  rsp_bus
);

   localparam int LEVEL_WIDTH = MAX_BITS_PER_SYMBOL / 2;

   logic [BPS_WIDTH-1:0]   bps_ff;
   logic [SCALE_WIDTH-1:0] rev_scale_ff;
   logic [BPS_WIDTH-1:0]   bps_eff;
   sym_ctrl_type           ctrl_in;
   sym_ctrl_type           ctrl_ff;
   logic                   valid_ff;
   logic                   stage_ready;
   logic                   merge_ready;
   logic [LEVEL_WIDTH-1:0] level_i;
   logic [LEVEL_WIDTH-1:0] level_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff       <= BPS_RESET;
         rev_scale_ff <= REV_SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BITS_PER_SYMBOL: bps_ff       <= csr_wdata[BPS_WIDTH-1:0];
            CSR_REV_SCALE:       rev_scale_ff <= csr_wdata[SCALE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // saturate the symbol size to what the output word holds
   assign bps_eff = (bps_ff > BPS_WIDTH'(MAX_BITS_PER_SYMBOL))
                  ? BPS_WIDTH'(MAX_BITS_PER_SYMBOL) : bps_ff;

   always_comb begin
      ctrl_in.bpsk = (bps_eff == BPS_WIDTH'(1));
      if (ctrl_in.bpsk) begin
         ctrl_in.half = HALF_WIDTH'(1);
      end else begin
         ctrl_in.half = bps_eff[BPS_WIDTH-1:1];
      end
   end

   assign stage_ready   = !valid_ff || merge_ready;
   assign req_bus.ready = stage_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready) begin
         ctrl_ff <= ctrl_in;
      end
   end

   qgd_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .LEVEL_WIDTH  (LEVEL_WIDTH)
   ) u_lane_i (
      .clock      (clock),
      .load_en    (stage_ready),
      .sample     (req_bus.sample_i),
      .rev_scale  (rev_scale_ff),
      .half       (ctrl_ff.half),
      .gray_level (level_i)
   );

   qgd_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .LEVEL_WIDTH  (LEVEL_WIDTH)
   ) u_lane_q (
      .clock      (clock),
      .load_en    (stage_ready),
      .sample     (req_bus.sample_q),
      .rev_scale  (rev_scale_ff),
      .half       (ctrl_ff.half),
      .gray_level (level_q)
   );

   qgd_merge #(
      .MAX_BITS_PER_SYMBOL (MAX_BITS_PER_SYMBOL),
      .LEVEL_WIDTH         (LEVEL_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_ff),
      .in_ready (merge_ready),
      .ctrl     (ctrl_ff),
      .level_i  (level_i),
      .level_q  (level_q),
      .rsp      (rsp_bus)
   );

   // an empty multiply stage always takes a transaction
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> req_bus.ready)
      else $error("empty multiply stage refused a transaction");

   // an accepted sample lands in the multiply stage
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> valid_ff)
      else $error("accepted sample lost before the multiply stage");

   // bpsk decisions carry a single bit
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && merge_ready && ctrl_ff.bpsk |=>
         (rsp_bus.symbol_bits >> 1) == '0)
      else $error("bpsk decision has upper bits set");

   // axis size never exceeds the lane width
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ctrl_ff.half <= HALF_WIDTH'(LEVEL_WIDTH))
      else $error("axis bit count beyond lane width");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the qam gray hard demapper: directed table, then random phases
module testbench;
   import qgd_pkg::*;

   localparam int MAX_BPS       = 8;
   localparam int SAMPLE_W      = 16;
   localparam int PIPE_LATENCY  = 2;
   localparam int RANDOM_PHASES = 24;
   localparam int PHASE_ITEMS   = 55;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   typedef struct packed {
      logic [3:0]  bps;
      logic [15:0] scale;
      logic [15:0] si;
      logic [15:0] sq;
      logic        typed;
      logic [7:0]  symbol;
   } stim_row_type;

   localparam stim_row_type DIRECTED [24] = '{
      '{4'd2,  16'd4096,  16'h0000, 16'h0000, 1'b1, 8'h03},
      '{4'd2,  16'd4096,  16'h8000, 16'h7FFF, 1'b1, 8'h01},
      '{4'd2,  16'd4096,  16'h7FFF, 16'h8000, 1'b1, 8'h02},
      '{4'd2,  16'd4096,  16'hFFFF, 16'hFFFF, 1'b0, 8'h00},
      '{4'd1,  16'd4096,  16'h0000, 16'h8000, 1'b1, 8'h01},
      '{4'd1,  16'd4096,  16'hFFFF, 16'h7FFF, 1'b1, 8'h00},
      '{4'd1,  16'd65535, 16'h7FFF, 16'h0000, 1'b1, 8'h01},
      '{4'd0,  16'd4096,  16'h7FFF, 16'h7FFF, 1'b1, 8'h00},
      '{4'd0,  16'd65535, 16'h8000, 16'h7FFF, 1'b1, 8'h00},
      '{4'd8,  16'd0,     16'h3039, 16'hCFC7, 1'b1, 8'hCC},
      '{4'd8,  16'd65535, 16'h7FFF, 16'h8000, 1'b1, 8'h80},
      '{4'd8,  16'd65535, 16'h8000, 16'h7FFF, 1'b1, 8'h08},
      '{4'd15, 16'd65535, 16'h7FFF, 16'h8000, 1'b1, 8'h80},
      '{4'd9,  16'd4096,  16'h0000, 16'h0000, 1'b1, 8'hCC},
      '{4'd7,  16'd4096,  16'h0000, 16'h0000, 1'b0, 8'h00},
      '{4'd3,  16'd4096,  16'h0800, 16'hF800, 1'b0, 8'h00},
      '{4'd5,  16'd4096,  16'h1000, 16'hF000, 1'b0, 8'h00},
      '{4'd4,  16'd4096,  16'h1000, 16'h0FFF, 1'b0, 8'h00},
      '{4'd4,  16'd4096,  16'hF000, 16'hEFFF, 1'b0, 8'h00},
      '{4'd6,  16'd4096,  16'h1000, 16'hF000, 1'b0, 8'h00},
      '{4'd6,  16'd8192,  16'h0400, 16'hFC00, 1'b0, 8'h00},
      '{4'd8,  16'd4096,  16'h7800, 16'h8800, 1'b0, 8'h00},
      '{4'd2,  16'd1,     16'h7FFF, 16'h8000, 1'b0, 8'h00},
      '{4'd8,  16'd65535, 16'h0001, 16'hFFFF, 1'b0, 8'h00}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   qgd_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_bus ();
   qgd_rsp_if #(.MAX_BITS_PER_SYMBOL(MAX_BPS)) rsp_bus ();

   logic [3:0]    cfg_bps;
   logic [15:0]   cfg_scale;
   flow_mode_type flow;
   logic [7:0]    expected_symbols [$];
   int            errors = 0;

   qam_gray_hard_demapper #(
      .MAX_BITS_PER_SYMBOL(MAX_BPS),
      .SAMPLE_WIDTH       (SAMPLE_W)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic logic [3:0] axis_code(input logic [15:0] sample, input int half);
      longint acc;
      longint lvl;
      longint top;
      top = (longint'(1) << half) - 1;
      acc = longint'($signed(sample)) * longint'(cfg_scale) + ((top + 1) <<< FRAC_BITS);
      lvl = (acc < 0) ? 0 : (acc >>> (FRAC_BITS + 1));
      if (lvl > top) begin
         lvl = top;
      end
      return 4'(lvl ^ (lvl >> 1));
   endfunction

   function automatic logic [7:0] predict_symbol(input logic [15:0] si, input logic [15:0] sq);
      logic [3:0] b;
      int         half;
      logic [3:0] ic;
      logic [3:0] qc;
      b    = (cfg_bps > MAX_BPS) ? 4'(MAX_BPS) : cfg_bps;
      half = (b == 1) ? 1 : b / 2;
      ic   = axis_code(si, half);
      qc   = axis_code(sq, half);
      if (b == 1) begin
         return 8'(ic);
      end
      return (8'(ic) << half) | 8'(qc);
   endfunction

   function automatic void queue_expected(input logic [7:0] symbol);
      expected_symbols = {expected_symbols, symbol};
   endfunction

   function automatic logic [15:0] pick_sample();
      logic [3:0] b;
      longint     m;
      longint     k;
      longint     target;
      b = (cfg_bps > MAX_BPS) ? 4'(MAX_BPS) : cfg_bps;
      m = (b == 1) ? 2 : longint'(1) << (b / 2);
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom());
         2: return 16'($urandom_range(0, 8191) - 4096);
         3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: begin
            if (cfg_scale == 0) begin
               return 16'($urandom());
            end
            // land on or next to a decision threshold
            k = $urandom_range(0, 32'(m));
            target = (((2 * k) - m) <<< FRAC_BITS) / longint'(cfg_scale)
                     + longint'($urandom_range(0, 4)) - 2;
            if (target > 32767) begin
               target = 32767;
            end
            if (target < -32768) begin
               target = -32768;
            end
            return 16'(target);
         end
      endcase
   endfunction

   function automatic logic sender_idles();
      case (flow)
         FLOW_SENDER_IDLE: return $urandom_range(0, 99) < 88;
         FLOW_BOTH:        return $urandom_range(0, 99) < 36;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (flow)
         FLOW_RECEIVER_STALL: return $urandom_range(0, 99) < 88;
         FLOW_BOTH:           return $urandom_range(0, 99) < 36;
         default:             return 1'b0;
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [3:0] bps, input logic [15:0] scale);
      logic [CSR_DATA_WIDTH-1:0] data;
      req_bus.valid <= 1'b0;
      while (expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY) @(posedge clock);
      data      = 16'($urandom());
      data[3:0] = bps;
      write_reg(CSR_BITS_PER_SYMBOL, data);
      write_reg(CSR_REV_SCALE, scale);
      // unused index must leave both registers alone
      write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 16'($urandom()));
      csr_wr_en <= 1'b0;
      cfg_bps   = bps;
      cfg_scale = scale;
   endtask

   task automatic send_sample(input logic [15:0] si, input logic [15:0] sq,
                              input logic typed, input logic [7:0] symbol);
      while (sender_idles()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.sample_i <= si;
      req_bus.sample_q <= sq;
      queue_expected(typed ? symbol : predict_symbol(si, sq));
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   initial begin
      logic [7:0] want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_symbols.size() == 0) begin
               errors++;
               $display("%0t: unexpected decision transaction, actual %02h",
                        $time, rsp_bus.symbol_bits);
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_bus.symbol_bits !== want) begin
                  errors++;
                  $display("%0t: symbol_bits mismatch, expected %02h, actual %02h",
                           $time, want, rsp_bus.symbol_bits);
               end
            end
         end
         rsp_bus.ready <= !receiver_stalls();
      end
   end

   initial begin
      stim_row_type row;
      logic [3:0]   bps;
      logic [15:0]  scale;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_BITS_PER_SYMBOL;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.sample_i <= '0;
      req_bus.sample_q <= '0;
      flow      = FLOW_FREE;
      cfg_bps   = BPS_RESET;
      cfg_scale = REV_SCALE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         if (row.bps != cfg_bps || row.scale != cfg_scale) begin
            apply_settings(row.bps, row.scale);
         end
         send_sample(row.si, row.sq, row.typed, row.symbol);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         bps = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8))
                                          : 4'($urandom_range(0, 15));
         case ($urandom_range(0, 5))
            0:       scale = '0;
            1:       scale = '1;
            2:       scale = REV_SCALE_RESET;
            default: scale = 16'($urandom_range(1, 65535));
         endcase
         apply_settings(bps, scale);
         flow = flow_mode_type'(phase % 4);
         repeat (PHASE_ITEMS) send_sample(pick_sample(), pick_sample(), 1'b0, 8'h00);
      end

      req_bus.valid <= 1'b0;
      while (expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
